// ===== hw/rtl/assert_macros.svh =====
// concurrent assertion helpers used by the bcfr checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define BCFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bcfr assertion failed");

// checked on every rising edge, reset included
`define BCFR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bcfr assertion failed");

`endif

// ===== hw/rtl/bcfr_pkg.sv =====
package bcfr_pkg;

	localparam int PACK_LEN = 1024;
	localparam int CNT_W    = $clog2(PACK_LEN + 1);
	localparam int IDX_W    = 10;
	localparam int ADDR_BYTES = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hFE;
	localparam logic [7:0] CMD_GO    = 8'h21;
	localparam logic [7:0] CMD_WRITE = 8'h31;
	localparam logic [7:0] CMD_ERASE = 8'h44;
	localparam logic [7:0] ACK_BYTE  = 8'h79;
	localparam logic [7:0] NACK_BYTE = 8'h1F;
	localparam logic [8:0] PAIR_SUM  = 9'h100;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_CMD,
		PH_CMPL,
		PH_ELEN,
		PH_WADDR,
		PH_WDATA,
		PH_WSUM,
		PH_STOPPED
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_ERASE  = 3'd1,
		EV_DATA   = 3'd2,
		EV_ACCEPT = 3'd3,
		EV_REJECT = 3'd4,
		EV_GO     = 3'd5
	} event_t;

	typedef struct packed {
		logic             reply_valid;
		logic [7:0]       reply_byte;
		event_t           event_res;
		logic [31:0]      address;
		logic [31:0]      erase_length;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] data_index;
	} result_t;

endpackage

// ===== hw/rtl/boot_command_frame_receiver_top.sv =====
// boot command frame receiver
// req channel: one word per received event, mode 0 carries a serial byte in
// rx_byte, mode 1 reports an expired read timeout (rx_byte ignored).
// rsp channel: exactly one result word per request word, in order. It holds
// reply_valid/reply_byte (ack 0x79 or nack 0x1F to send to the host),
// event_res (erase request, write data byte, write accepted/rejected, go)
// and the address, erase_length, data_byte and data_index that go with it.
// a request word is registered in the input register at the edge that
// accepts it, and its result is registered in the result register when rsp
// is free, from which it shows on rsp. one word per cycle is taken as long
// as rsp is not stalled.
// when rsp_stall holds the result register, the input register still fills
// once and req_stall then rises until the result is taken; nothing is lost.
// reset (arst_n low) empties both registers and returns the frame decoder
// to the sync hunt; after a go command the block answers every further word
// with an all-zero result until the next reset.
module boot_command_frame_receiver_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        mode,
	input  logic [7:0]                  rx_byte,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        reply_valid,
	output logic [7:0]                  reply_byte,
	output logic [2:0]                  event_res,
	output logic [31:0]                 address,
	output logic [31:0]                 erase_length,
	output logic [7:0]                  data_byte,
	output logic [bcfr_pkg::IDX_W-1:0]  data_index
);
	import bcfr_pkg::*;

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] rx_byte_s1;
	logic       rsp_valid_q;
	result_t    res_q;
	result_t    res;
	logic       out_free;
	logic       step;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign step      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			mode_s1    <= mode;
			rx_byte_s1 <= rx_byte;
		end
	end

	bcfr_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.mode    (mode_s1),
		.rx_byte (rx_byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign rsp_valid    = rsp_valid_q;
	assign reply_valid  = res_q.reply_valid;
	assign reply_byte   = res_q.reply_byte;
	assign event_res    = res_q.event_res;
	assign address      = res_q.address;
	assign erase_length = res_q.erase_length;
	assign data_byte    = res_q.data_byte;
	assign data_index   = res_q.data_index;

endmodule

// ===== hw/rtl/bcfr_fsm.sv =====
module bcfr_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              mode,
	input  logic [7:0]        rx_byte,
	output bcfr_pkg::result_t res
);
	import bcfr_pkg::*;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d, count_inc;
	logic [7:0]       cmd_q, cmd_d;
	logic [31:0]      word_q, word_d, word_shift;
	logic [7:0]       xor_q, xor_d;
	logic             pair_ok;

	assign count_inc  = count_q + CNT_W'(1);
	assign word_shift = {word_q[23:0], rx_byte};
	assign pair_ok    = ({1'b0, cmd_q} + {1'b0, rx_byte}) == PAIR_SUM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			cmd_q   <= '0;
			word_q  <= '0;
			xor_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			cmd_q   <= cmd_d;
			word_q  <= word_d;
			xor_q   <= xor_d;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		cmd_d   = cmd_q;
		word_d  = word_q;
		xor_d   = xor_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (!mode && rx_byte == SYNC_BYTE)
					phase_d = PH_CMD;
			end
			PH_CMD: begin
				if (mode) begin
					phase_d = PH_HUNT;
				end else begin
					cmd_d   = rx_byte;
					phase_d = PH_CMPL;
				end
			end
			PH_CMPL: begin
				phase_d = PH_HUNT;
				if (!mode && pair_ok) begin
					word_d  = '0;
					count_d = '0;
					xor_d   = '0;
					if (cmd_q == CMD_ERASE)
						phase_d = PH_ELEN;
					else if (cmd_q == CMD_WRITE)
						phase_d = PH_WADDR;
					else if (cmd_q == CMD_GO)
						phase_d = PH_STOPPED;
				end
			end
			PH_ELEN: begin
				if (mode) begin
					word_d  = '0;
					phase_d = PH_HUNT;
				end else begin
					word_d  = word_shift;
					count_d = count_inc;
					if (count_inc >= CNT_W'(ADDR_BYTES))
						phase_d = PH_HUNT;
				end
			end
			PH_WADDR: begin
				if (mode) begin
					phase_d = PH_HUNT;
				end else begin
					word_d  = word_shift;
					xor_d   = xor_q ^ rx_byte;
					count_d = count_inc;
					if (count_inc >= CNT_W'(ADDR_BYTES)) begin
						count_d = '0;
						phase_d = PH_WDATA;
					end
				end
			end
			PH_WDATA: begin
				if (mode) begin
					phase_d = PH_HUNT;
				end else begin
					xor_d   = xor_q ^ rx_byte;
					count_d = count_inc;
					if (count_inc >= CNT_W'(PACK_LEN))
						phase_d = PH_WSUM;
				end
			end
			PH_WSUM: begin
				phase_d = PH_HUNT;
			end
			PH_STOPPED: begin
				phase_d = PH_STOPPED;
			end
		endcase
	end

	// result word for the current input
	always_comb begin
		res = '0;
		unique case (phase_q)
			PH_HUNT, PH_CMD, PH_STOPPED: begin
				res = '0;
			end
			PH_CMPL: begin
				if (!mode && pair_ok) begin
					res.reply_valid = 1'b1;
					if (cmd_q == CMD_ERASE || cmd_q == CMD_WRITE) begin
						res.reply_byte = ACK_BYTE;
					end else if (cmd_q == CMD_GO) begin
						res.reply_byte = ACK_BYTE;
						res.event_res  = EV_GO;
					end else begin
						res.reply_byte = NACK_BYTE;
					end
				end
			end
			PH_ELEN: begin
				if (mode || count_inc >= CNT_W'(ADDR_BYTES)) begin
					res.reply_valid  = 1'b1;
					res.reply_byte   = ACK_BYTE;
					res.event_res    = EV_ERASE;
					res.erase_length = mode ? 32'd0 : word_shift;
				end
			end
			PH_WADDR: begin
				if (mode) begin
					res.reply_valid = 1'b1;
					res.reply_byte  = NACK_BYTE;
					res.event_res   = EV_REJECT;
				end
			end
			PH_WDATA: begin
				res.address = word_q;
				if (mode) begin
					res.reply_valid = 1'b1;
					res.reply_byte  = NACK_BYTE;
					res.event_res   = EV_REJECT;
				end else begin
					res.event_res  = EV_DATA;
					res.data_byte  = rx_byte;
					res.data_index = count_q[IDX_W-1:0];
				end
			end
			PH_WSUM: begin
				res.address     = word_q;
				res.reply_valid = 1'b1;
				if (!mode && rx_byte == xor_q) begin
					res.reply_byte = ACK_BYTE;
					res.event_res  = EV_ACCEPT;
				end else begin
					res.reply_byte = NACK_BYTE;
					res.event_res  = EV_REJECT;
				end
			end
		endcase
	end

endmodule

// ===== hw/rtl/bcfr_checker.sv =====
`include "assert_macros.svh"

module bcfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        mode,
	input logic [7:0]                  rx_byte,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic                        reply_valid,
	input logic [7:0]                  reply_byte,
	input logic [2:0]                  event_res,
	input logic [31:0]                 address,
	input logic [31:0]                 erase_length,
	input logic [7:0]                  data_byte,
	input logic [bcfr_pkg::IDX_W-1:0]  data_index
);
	import bcfr_pkg::*;

	// a stalled result word holds
	`BCFR_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(reply_byte) && $stable(event_res) && $stable(data_index))

	// a reply is always ack or nack, and no reply leaves the byte clear
	`BCFR_ASSERT(a_reply_code, clk, arst_n, rsp_valid |-> (reply_valid && (reply_byte == ACK_BYTE || reply_byte == NACK_BYTE)) || (!reply_valid && reply_byte == 8'd0))

	// a streamed data byte never carries a reply or an erase length
	`BCFR_ASSERT(a_data_quiet, clk, arst_n, rsp_valid && event_res == EV_DATA |-> !reply_valid && erase_length == 32'd0)

	// erase, accept and go are acknowledged
	`BCFR_ASSERT(a_ack_events, clk, arst_n, rsp_valid && (event_res == EV_ERASE || event_res == EV_ACCEPT || event_res == EV_GO) |-> reply_valid && reply_byte == ACK_BYTE)

endmodule

bind boot_command_frame_receiver_top bcfr_checker u_bcfr_checker (.*);
